>>> rtl/pve_pkg.sv
// Package for the prefix-length varint encoder.
// Holds the queue entry type and the fixed code constants; depends on nothing.
`default_nettype none

package pve_pkg;

  localparam logic [7:0] SmallLimit = 8'h7F;
  localparam logic [3:0] MaxCodeBytes = 4'd9;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  total;
    logic [7:0]  header;
    logic        fits;
  } pve_entry_t;

endpackage

`default_nettype wire

>>> rtl/pve_front.sv
// Front part of the varint encoder: accepts requests, finds the code length,
// header byte and space check, and holds the result in one register stage.
// Depends on pve_pkg.
`default_nettype none

module pve_front
  import pve_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [63:0] value,
  input  wire logic [3:0]  space_bytes,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             st_valid,
  output pve_entry_t       st_entry,
  input  wire logic        st_ready
);

  pve_entry_t entry_next;
  logic [3:0] space_sat;
  logic [3:0] payload;

  always_comb begin
    space_sat = (space_bytes > MaxCodeBytes) ? MaxCodeBytes : space_bytes;
    if (value[63:14] == '0) begin
      payload = 4'd1;
    end else if (value[63:21] == '0) begin
      payload = 4'd2;
    end else if (value[63:28] == '0) begin
      payload = 4'd3;
    end else if (value[63:35] == '0) begin
      payload = 4'd4;
    end else if (value[63:42] == '0) begin
      payload = 4'd5;
    end else if (value[63:49] == '0) begin
      payload = 4'd6;
    end else if (value[63:56] == '0) begin
      payload = 4'd7;
    end else begin
      payload = 4'd8;
    end
    entry_next.value = value;
    if (value <= 64'(SmallLimit)) begin
      entry_next.total  = 4'd1;
      entry_next.header = value[7:0];
    end else begin
      entry_next.total = payload + 4'd1;
      case (payload)
        4'd1:    entry_next.header = {2'b10, value[13:8]};
        4'd2:    entry_next.header = {3'b110, value[20:16]};
        4'd3:    entry_next.header = {4'b1110, value[27:24]};
        4'd4:    entry_next.header = {5'b11110, value[34:32]};
        4'd5:    entry_next.header = {6'b111110, value[41:40]};
        4'd6:    entry_next.header = {7'b1111110, value[48]};
        4'd7:    entry_next.header = 8'hFE;
        default: entry_next.header = 8'hFF;
      endcase
    end
    entry_next.fits = (space_sat >= entry_next.total);
  end

  assign in_ready = !st_valid || st_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pve_fifo.sv
// Short queue between the front and back parts of the varint encoder.
// Holds classified requests in a small register array; depends on pve_pkg.
`default_nettype none

module pve_fifo
  import pve_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_valid,
  output logic            wr_ready,
  input  wire pve_entry_t wr_entry,
  output logic            rd_valid,
  input  wire logic       rd_ready,
  output pve_entry_t      rd_entry
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  pve_entry_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic push;
  logic pop;

  assign wr_ready = (count != CntW'(DEPTH));
  assign rd_valid = (count != '0);
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pve_back.sv
// Back part of the varint encoder: walks the queue head one byte per cycle
// (unless stalled) into the output register, header first. Uses pve_pkg.
`default_nettype none

module pve_back
  import pve_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  output logic            head_ready,
  input  wire pve_entry_t head_entry,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            last,
  output logic [3:0]      encoded_length
);

  logic [3:0] idx;
  logic [2:0] sel;
  logic       load;
  logic       is_last;
  logic [7:0] byte_next;

  assign load = !out_valid || out_ready;
  assign sel = 3'(head_entry.total - 4'd1 - idx);

  always_comb begin
    if (!head_entry.fits) begin
      is_last = 1'b1;
      byte_next = 8'h00;
    end else if (idx == 4'd0) begin
      is_last = (head_entry.total == 4'd1);
      byte_next = head_entry.header;
    end else begin
      is_last = (idx == head_entry.total - 4'd1);
      byte_next = head_entry.value[{sel, 3'b000} +: 8];
    end
  end

  assign head_ready = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= is_last ? 4'd0 : idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte <= byte_next;
      byte_valid <= head_entry.fits;
      last <= is_last;
      encoded_length <= head_entry.total;
    end
  end

endmodule

`default_nettype wire

>>> rtl/prefix_varint_encoder.sv
// Top level of the prefix-length varint encoder.
// Instantiates pve_front, pve_fifo and pve_back; depends on pve_pkg.
//
// Usage: each request on the input channel (value, space_bytes under
// in_valid/in_ready) becomes a length-prefixed big-endian code of 1 to 9
// bytes on the output channel (out_byte, byte_valid, last, encoded_length
// under out_valid/out_ready), one byte per result, header first.
// If the code does not fit in space_bytes (saturated at nine), one result
// with byte_valid low, out_byte zero and last high is sent instead.
// A request passes through the front stage register, the queue and the
// output register. The back part emits one result per cycle while the
// queue holds an entry and out_ready does not stall it; a request gives
// encoded_length results when the code fits and one when it does not.
// Requests are taken back to back while the queue has room.
// Reset is synchronous and empties the front stage, queue and output
// register. When the receiver stalls, the output register holds its byte,
// the queue fills, and in_ready drops once the front stage is also full.
`default_nettype none

module prefix_varint_encoder
  import pve_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] value,
  input  wire logic [3:0]  space_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             last,
  output logic [3:0]       encoded_length
);

  logic       st_valid;
  logic       st_ready;
  pve_entry_t st_entry;
  logic       head_valid;
  logic       head_ready;
  pve_entry_t head_entry;

  pve_front u_front (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .space_bytes(space_bytes),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .st_valid   (st_valid),
    .st_entry   (st_entry),
    .st_ready   (st_ready)
  );

  pve_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(st_valid),
    .wr_ready(st_ready),
    .wr_entry(st_entry),
    .rd_valid(head_valid),
    .rd_ready(head_ready),
    .rd_entry(head_entry)
  );

  pve_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_ready    (head_ready),
    .head_entry    (head_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last          (last),
    .encoded_length(encoded_length)
  );

`ifndef ASSERT_OFF
  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && out_byte == 8'h00)
    else $error("Result without space is not a single zero byte.");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> encoded_length >= 4'd1 && encoded_length <= MaxCodeBytes)
    else $error("Encoded length out of range.");

  a_one_byte_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && encoded_length == 4'd1 |-> last)
    else $error("One-byte code not marked last.");

  a_len_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last ##1 out_valid |->
      encoded_length == $past(encoded_length))
    else $error("Encoded length changed inside one code.");
`endif

endmodule

`default_nettype wire

>>> tb/tb_prefix_varint_encoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for prefix_varint_encoder: directed and random requests with
// random sender gaps and receiver stalls, checked byte by byte against an inline predictor.
// Depends on pve_pkg and the prefix_varint_encoder RTL.

module tb_prefix_varint_encoder;
  import pve_pkg::*;

  localparam int RandomRequests = 236;
  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 12;
  localparam int MaxReported = 10;

  typedef struct {
    logic [63:0] value;
    logic [3:0]  space;
  } request_t;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic [3:0] length;
  } code_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] value = 64'd0;
  logic [3:0]  space_bytes = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [3:0]  encoded_length;

  request_t   pending_requests[$];
  code_byte_t expected_bytes[$];

  int errors = 0;
  int accepted_requests = 0;
  int checked_bytes = 0;
  int short_results = 0;
  int length_seen[1:9];
  int cycles = 0;

  prefix_varint_encoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .space_bytes(space_bytes),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .byte_valid(byte_valid),
    .last(last),
    .encoded_length(encoded_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [3:0] code_length(logic [63:0] v);
    int k;
    if (v <= 64'(SmallLimit)) return 4'd1;
    k = 1;
    while (k < 8 && (v >> (8 * k)) > (64'(SmallLimit) >> k)) k++;
    return 4'(k + 1);
  endfunction

  // Pushes every byte that one request should produce onto expected_bytes.
  function automatic void predict_code(logic [63:0] v, logic [3:0] space);
    logic [3:0]  room;
    logic [3:0]  total;
    logic [7:0]  mask;
    logic [63:0] top_bits;
    int          payload;
    room = (space > MaxCodeBytes) ? MaxCodeBytes : space;
    total = code_length(v);
    payload = int'(total) - 1;
    if (room < total) begin
      expected_bytes.push_back('{8'h00, 1'b0, 1'b1, total});
    end else if (payload == 0) begin
      expected_bytes.push_back('{v[7:0], 1'b1, 1'b1, total});
    end else begin
      mask = 8'hFF << (8 - payload);
      top_bits = (payload < 8) ? (v >> (8 * payload)) : 64'd0;
      expected_bytes.push_back('{mask | top_bits[7:0], 1'b1, 1'b0, total});
      for (int i = 0; i < payload; i++) begin
        top_bits = v >> (8 * (payload - 1 - i));
        expected_bytes.push_back('{top_bits[7:0], 1'b1, i == payload - 1, total});
      end
    end
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  int       burst_left = 0;
  int       gap_left = 0;
  request_t next_request;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_code(value, space_bytes);
        accepted_requests++;
      end
      if (!in_valid || in_ready) begin
        if (burst_left == 0 && gap_left == 0) burst_left = $urandom_range(1, 16);
        if (burst_left > 0 && pending_requests.size() > 0) begin
          next_request = pending_requests.pop_front();
          value <= next_request.value;
          space_bytes <= next_request.space;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Receiver: stall mode is redrawn at random from four patterns, with two long hold-offs.
  int ready_cycles = 0;
  int hold_left = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    ready_cycles++;
    if (ready_cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (ready_cycles == 150 || ready_cycles == 900) hold_left = 100;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (ready_cycles % 3 != 0);
      endcase
    end
  end

  code_byte_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      checked_bytes++;
      if (!byte_valid) short_results++;
      if (encoded_length >= 1 && encoded_length <= 9) length_seen[encoded_length]++;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= MaxReported) begin
          $display("ERROR: unexpected result byte=%h valid=%b last=%b len=%0d",
                   out_byte, byte_valid, last, encoded_length);
        end
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data || byte_valid !== want.present || last !== want.last ||
            encoded_length !== want.length) begin
          errors++;
          if (errors <= MaxReported) begin
            $display("ERROR: result %0d expected byte=%h valid=%b last=%b len=%0d,",
                     checked_bytes, want.data, want.present, want.last, want.length);
            $display("       got byte=%h valid=%b last=%b len=%0d",
                     out_byte, byte_valid, last, encoded_length);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_bytes.size());
      $display("prefix_varint_encoder test failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] v;
    logic [63:0] raw;
    int          nbits;
    int          need;
    int          pick;
    logic [3:0]  space;

    foreach (length_seen[i]) length_seen[i] = 0;

    pending_requests.push_back('{64'h0, 4'd1});
    pending_requests.push_back('{64'h7F, 4'd9});
    pending_requests.push_back('{64'h7F, 4'd0});
    pending_requests.push_back('{64'h80, 4'd2});
    pending_requests.push_back('{64'h80, 4'd1});
    for (int k = 1; k < 8; k++) begin
      pending_requests.push_back('{(64'd1 << (7 * k + 7)) - 64'd1, 4'(k + 1)});
      pending_requests.push_back('{64'd1 << (7 * k + 7), 4'd15});
    end
    pending_requests.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd9});
    pending_requests.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8});
    pending_requests.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15});
    pending_requests.push_back('{64'h0123_4567_89AB_CDEF, 4'd12});
    pending_requests.push_back('{64'h5A, 4'd10});

    // Random part: values of random bit length so every code length shows up;
    // most requests have room, some have exactly one byte too few.
    for (int n = 0; n < RandomRequests; n++) begin
      nbits = $urandom_range(0, 64);
      raw = {$urandom, $urandom};
      v = (nbits == 0) ? 64'd0 : raw >> (64 - nbits);
      need = code_length(v);
      pick = $urandom_range(0, 9);
      if (pick < 6) space = 4'($urandom_range(need, 15));
      else if (pick < 8) space = 4'($urandom_range(0, 15));
      else space = 4'(need - 1);
      pending_requests.push_back('{v, space});
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (expected_bytes.size() != 0) errors++;

    $display("Covered %0d requests, %0d result bytes checked, %0d space-too-small results.",
             accepted_requests, checked_bytes, short_results);
    $display("Results per code length 1..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d; errors %0d.",
             length_seen[1], length_seen[2], length_seen[3], length_seen[4], length_seen[5],
             length_seen[6], length_seen[7], length_seen[8], length_seen[9], errors);
    if (errors == 0) begin
      $display("prefix_varint_encoder test passed");
    end else begin
      $display("prefix_varint_encoder test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pve_pkg.sv
rtl/pve_front.sv
rtl/pve_fifo.sv
rtl/pve_back.sv
rtl/prefix_varint_encoder.sv
tb/tb_prefix_varint_encoder.sv
